@@ sv/accel_tilt_angles_core_macros.svh @@
`ifndef ACCEL_TILT_ANGLES_CORE_MACROS_SVH
`define ACCEL_TILT_ANGLES_CORE_MACROS_SVH

// Clocked check, off while reset is held.
`define ATL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check, also evaluated during reset.
`define ATL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/atl_pkg.sv @@
package atl_pkg;

  localparam int SMP_W    = 16;
  localparam int STAT_W   = 8;
  localparam int OUT_W    = 16;

  localparam logic [STAT_W-1:0] NEW_MASK = 8'h03;

  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int CORDIC_ITERS_DEF    = 16;

  // |v| * 16 and floor(sqrt((a^2 + b^2) << 8)) both fit in 20 bits
  localparam int MAG_W    = 20;
  localparam int ROOT_W   = MAG_W;
  localparam int PROD_W   = 31;
  localparam int SUM_W    = 32;
  localparam int SQ_PRE   = 8;
  localparam int SQ_OP_W  = SUM_W + SQ_PRE;
  localparam int REM_W    = ROOT_W + 2;
  localparam int SQ_CNT_W = $clog2(ROOT_W);

  localparam int CORD_PRE  = 8;
  localparam int CX_W      = 32;
  localparam int ACC_W     = 29;
  localparam int RND_W     = ACC_W - 1;
  localparam int TAB_FRAC  = 20;
  localparam int TAB_LEN   = 24;
  localparam int TAB_W     = 27;
  localparam int TAB_IDX_W = 5;

  localparam logic [TAB_W-1:0] DEG90_TAB = 27'd94371840;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_CORD_GO,
    ST_CORD_WAIT,
    ST_DONE
  } atl_state_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } atl_axis_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] num;
    logic [MAG_W-1:0] den;
    logic             neg;
  } atl_cord_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [OUT_W-1:0] angle;
  } atl_cord_rsp_t;

  // atan(2^-i) in degrees, scaled by 2^TAB_FRAC
  function automatic logic [TAB_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      5'd0:    v = 27'd47185920;
      5'd1:    v = 27'd27855475;
      5'd2:    v = 27'd14718068;
      5'd3:    v = 27'd7471121;
      5'd4:    v = 27'd3750058;
      5'd5:    v = 27'd1876857;
      5'd6:    v = 27'd938658;
      5'd7:    v = 27'd469357;
      5'd8:    v = 27'd234682;
      5'd9:    v = 27'd117342;
      5'd10:   v = 27'd58671;
      5'd11:   v = 27'd29335;
      5'd12:   v = 27'd14668;
      5'd13:   v = 27'd7334;
      5'd14:   v = 27'd3667;
      5'd15:   v = 27'd1833;
      5'd16:   v = 27'd917;
      5'd17:   v = 27'd458;
      5'd18:   v = 27'd229;
      5'd19:   v = 27'd115;
      5'd20:   v = 27'd57;
      5'd21:   v = 27'd29;
      5'd22:   v = 27'd14;
      5'd23:   v = 27'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/atl_in_if.sv @@
interface atl_in_if import atl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [SMP_W-1:0] acc_x_in;
  logic signed [SMP_W-1:0] acc_y_in;
  logic signed [SMP_W-1:0] acc_z_in;

  modport source (output valid, status, acc_x_in, acc_y_in, acc_z_in, input ready);
  modport sink   (input valid, status, acc_x_in, acc_y_in, acc_z_in, output ready);
endinterface

@@ sv/atl_out_if.sv @@
interface atl_out_if import atl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] angle_x;
  logic signed [OUT_W-1:0] angle_y;
  logic signed [OUT_W-1:0] angle_z;
  logic                    sample_taken;

  modport source (output valid, angle_x, angle_y, angle_z, sample_taken, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, sample_taken, output ready);
endinterface

@@ sv/accel_tilt_angles_core.sv @@
// Accelerometer tilt angles. Each input transaction carries a status byte and an X, Y, Z
// sample; the sample replaces the held one when status bit 0 or 1 is set. The block then
// returns one result transaction with the X, Y and Z tilt angles of the held sample in
// degrees scaled by 2^ANGLE_FRAC_BITS, and sample_taken. The three angles are worked out
// one after the other: a single 16x16 squarer builds each sum of squares, a shared
// bit-pair square root unit gives 20 root bits, and a shared vectoring CORDIC unit
// runs CORDIC_ITERS iterations per arctangent; an axis with a zero denominator skips
// the rotations. in_ready is high only between transactions. A finished result is held
// in an output register, so the next transaction can be accepted while the previous
// result waits; a second finished result waits until that register is free.
module accel_tilt_angles_core import atl_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_ITERS    = CORDIC_ITERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  atl_in_if.sink    in_if,
  atl_out_if.source out_if
);

`include "accel_tilt_angles_core_macros.svh"

  atl_state_t state_r, state_nxt;
  atl_axis_t  axis_r, axis_nxt;

  logic signed [SMP_W-1:0] x_r, y_r, z_r;
  logic                    take_r;
  logic [PROD_W-1:0]       prod_r;
  logic [PROD_W-1:0]       sum_r;
  logic [ROOT_W-1:0]       root_r;
  logic signed [OUT_W-1:0] ang_x_r, ang_y_r, ang_z_r;
  logic signed [OUT_W-1:0] out_x_r, out_y_r, out_z_r;
  logic                    out_take_r;
  logic                    out_valid_r;

  logic                    in_acc;
  logic                    out_load;
  logic                    take_in;
  logic signed [SMP_W-1:0] sq_a, sq_b, sq_op;
  logic signed [SUM_W-1:0] sq_full;
  logic [SQ_OP_W-1:0]      sq_operand;
  logic [SMP_W-1:0]        abs_x, abs_y, abs_z;
  logic                    sq_start;
  logic                    sq_done;
  logic [ROOT_W-1:0]       sq_root;
  logic                    cord_start;
  atl_cord_req_t           cord_req;
  atl_cord_rsp_t           cord_rsp;

  assign in_acc  = in_if.valid && in_if.ready;
  assign take_in = |(in_if.status & NEW_MASK);

  assign abs_x = x_r[SMP_W-1] ? SMP_W'(-x_r) : SMP_W'(x_r);
  assign abs_y = y_r[SMP_W-1] ? SMP_W'(-y_r) : SMP_W'(y_r);
  assign abs_z = z_r[SMP_W-1] ? SMP_W'(-z_r) : SMP_W'(z_r);

  // per-axis operand selection
  always_comb begin
    sq_a           = y_r;
    sq_b           = z_r;
    cord_req.start = cord_start;
    cord_req.num   = {abs_x, 4'b0000};
    cord_req.den   = root_r;
    cord_req.neg   = x_r[SMP_W-1];
    unique case (axis_r)
      AXIS_X: begin
        sq_a         = y_r;
        sq_b         = z_r;
        cord_req.num = {abs_x, 4'b0000};
        cord_req.den = root_r;
        cord_req.neg = x_r[SMP_W-1];
      end
      AXIS_Y: begin
        sq_a         = x_r;
        sq_b         = z_r;
        cord_req.num = {abs_y, 4'b0000};
        cord_req.den = root_r;
        cord_req.neg = y_r[SMP_W-1];
      end
      AXIS_Z: begin
        sq_a         = x_r;
        sq_b         = y_r;
        cord_req.num = root_r;
        cord_req.den = {abs_z, 4'b0000};
        cord_req.neg = z_r[SMP_W-1];
      end
      default: begin
        sq_a         = y_r;
        sq_b         = z_r;
        cord_req.num = {abs_x, 4'b0000};
        cord_req.den = root_r;
        cord_req.neg = x_r[SMP_W-1];
      end
    endcase
  end

  assign sq_op      = (state_r == ST_SQ_B) ? sq_b : sq_a;
  assign sq_full    = SUM_W'(sq_op) * SUM_W'(sq_op);
  assign sq_operand = {SUM_W'(sum_r) + SUM_W'(prod_r), SQ_PRE'(0)};

  always_comb begin
    state_nxt  = state_r;
    axis_nxt   = axis_r;
    sq_start   = 1'b0;
    cord_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          axis_nxt  = AXIS_X;
          state_nxt = ST_SQ_A;
        end
      end
      ST_SQ_A:    state_nxt = ST_SQ_B;
      ST_SQ_B:    state_nxt = ST_ROOT_GO;
      ST_ROOT_GO: begin
        sq_start  = 1'b1;
        state_nxt = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sq_done) begin
          state_nxt = ST_CORD_GO;
        end
      end
      ST_CORD_GO: begin
        cord_start = 1'b1;
        state_nxt  = ST_CORD_WAIT;
      end
      ST_CORD_WAIT: begin
        if (cord_rsp.done) begin
          unique case (axis_r)
            AXIS_X: begin
              axis_nxt  = AXIS_Y;
              state_nxt = ST_SQ_A;
            end
            AXIS_Y: begin
              axis_nxt  = AXIS_Z;
              state_nxt = ST_SQ_A;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= AXIS_X;
      out_valid_r <= 1'b0;
      x_r         <= '0;
      y_r         <= '0;
      z_r         <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && take_in) begin
        x_r <= in_if.acc_x_in;
        y_r <= in_if.acc_y_in;
        z_r <= in_if.acc_z_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      take_r <= take_in;
    end
    if (state_r == ST_SQ_A) begin
      prod_r <= PROD_W'(sq_full);
    end
    if (state_r == ST_SQ_B) begin
      prod_r <= PROD_W'(sq_full);
      sum_r  <= prod_r;
    end
    if (state_r == ST_ROOT_WAIT && sq_done) begin
      root_r <= sq_root;
    end
    if (state_r == ST_CORD_WAIT && cord_rsp.done) begin
      unique case (axis_r)
        AXIS_X:  ang_x_r <= cord_rsp.angle;
        AXIS_Y:  ang_y_r <= cord_rsp.angle;
        default: ang_z_r <= cord_rsp.angle;
      endcase
    end
    if (out_load) begin
      out_x_r    <= ang_x_r;
      out_y_r    <= ang_y_r;
      out_z_r    <= ang_z_r;
      out_take_r <= take_r;
    end
  end

  atl_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (sq_operand),
    .done    (sq_done),
    .root    (sq_root)
  );

  atl_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_ITERS    (CORDIC_ITERS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cord_req),
    .rsp   (cord_rsp)
  );

  assign in_if.ready         = (state_r == ST_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.angle_x      = out_x_r;
  assign out_if.angle_y      = out_y_r;
  assign out_if.angle_z      = out_z_r;
  assign out_if.sample_taken = out_take_r;

  `ATL_ASSERT(a_one_in_flight, in_acc |=> !in_if.ready, "input accepted while busy")
  `ATL_ASSERT(a_root_expected, sq_done |-> (state_r == ST_ROOT_WAIT), "stray root done")
  `ATL_ASSERT(a_cord_expected, cord_rsp.done |-> (state_r == ST_CORD_WAIT), "stray cordic done")
  `ATL_ASSERT(a_done_holds, (state_r == ST_DONE && out_valid_r && !out_if.ready) |=>
    (state_r == ST_DONE), "result dropped while output pending")
  `ATL_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r),
    "reset did not clear control")

endmodule

@@ sv/atl_sqrt.sv @@
module atl_sqrt import atl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SQ_OP_W-1:0] operand,
  output logic               done,
  output logic [ROOT_W-1:0]  root
);

  logic [SQ_OP_W-1:0]  op_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic                fits;

  // one result bit per cycle: bring down two operand bits, try root*4+1
  assign rem_sh = {rem_r, op_r[SQ_OP_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SQ_CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= operand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      op_r   <= op_r << 2;
      rem_r  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ sv/atl_cordic.sv @@
module atl_cordic import atl_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_ITERS    = CORDIC_ITERS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  atl_cord_req_t req,
  output atl_cord_rsp_t rsp
);

  localparam int ITER_W = $clog2(CORDIC_ITERS);
  localparam int SHIFT  = TAB_FRAC - ANGLE_FRAC_BITS;

  logic signed [CX_W-1:0]  cx_r;
  logic signed [CX_W-1:0]  cy_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    neg_r;
  logic [ITER_W-1:0]       cnt_r;
  logic                    busy_r;
  logic                    fin_r;
  logic                    done_r;
  logic signed [OUT_W-1:0] angle_r;

  logic signed [CX_W-1:0]  cx_sh;
  logic signed [CX_W-1:0]  cy_sh;
  logic signed [ACC_W-1:0] tab_s;
  logic [RND_W-1:0]        clamped;
  logic [RND_W-1:0]        rnd;
  logic [OUT_W-1:0]        angle_pos;
  logic [OUT_W-1:0]        angle_fin;

  assign cx_sh = cx_r >>> cnt_r;
  assign cy_sh = cy_r >>> cnt_r;
  assign tab_s = signed'(ACC_W'(atan_entry(TAB_IDX_W'(cnt_r))));

  // clamp to [0, 90 deg], round half up, then sign and saturate
  always_comb begin
    if (acc_r[ACC_W-1]) begin
      clamped = '0;
    end else if (acc_r[RND_W-1:0] > RND_W'(DEG90_TAB)) begin
      clamped = RND_W'(DEG90_TAB);
    end else begin
      clamped = acc_r[RND_W-1:0];
    end
    rnd       = (clamped + (RND_W'(1) << (SHIFT - 1))) >> SHIFT;
    angle_pos = (rnd > RND_W'(32767)) ? 16'h7fff : rnd[OUT_W-1:0];
    if (neg_r) begin
      angle_fin = (rnd >= RND_W'(32768)) ? 16'h8000 : OUT_W'(-rnd[OUT_W-1:0]);
    end else begin
      angle_fin = angle_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (req.start) begin
        cnt_r <= '0;
        // zero denominator: skip the rotations
        if (req.den == '0) begin
          fin_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ITER_W'(CORDIC_ITERS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cx_r  <= CX_W'({req.den, CORD_PRE'(0)});
      cy_r  <= CX_W'({req.num, CORD_PRE'(0)});
      neg_r <= req.neg;
      if (req.den == '0 && req.num != '0) begin
        acc_r <= ACC_W'(DEG90_TAB);
      end else begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      if (!cy_r[CX_W-1]) begin
        cx_r  <= cx_r + cy_sh;
        cy_r  <= cy_r - cx_sh;
        acc_r <= acc_r + tab_s;
      end else begin
        cx_r  <= cx_r - cy_sh;
        cy_r  <= cy_r + cx_sh;
        acc_r <= acc_r - tab_s;
      end
    end
    if (fin_r) begin
      angle_r <= signed'(angle_fin);
    end
  end

  assign rsp.done  = done_r;
  assign rsp.angle = angle_r;

endmodule

@@ bench/accel_tilt_angles_core_tb.sv @@
module accel_tilt_angles_core_tb import atl_pkg::*; ();

  localparam int FRAC       = ANGLE_FRAC_BITS_DEF;
  localparam int ITERS      = CORDIC_ITERS_DEF;
  localparam int ATAN_FRAC  = 20;
  localparam longint DEG90_FIX = 64'sd90 <<< ATAN_FRAC;

  localparam logic signed [OUT_W-1:0] P90 = OUT_W'(90 * (1 << FRAC));
  localparam logic signed [OUT_W-1:0] M90 = -P90;
  localparam logic signed [SMP_W-1:0] SMAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMIN = 16'sh8000;

  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_AFTER   = 30;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 400;

  // atan(2^-i) in degrees, 20 fraction bits
  localparam longint ATAN_DEG [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  // which result fields of a directed row are typed in: angle_x, angle_y, angle_z, taken
  localparam logic [3:0] TYPED_ALL  = 4'b1111;
  localparam logic [3:0] TYPED_XZ   = 4'b1011;
  localparam logic [3:0] TYPED_YZ   = 4'b0111;
  localparam logic [3:0] TYPED_FLAG = 4'b0001;

  typedef struct packed {
    logic signed [OUT_W-1:0] angle_x;
    logic signed [OUT_W-1:0] angle_y;
    logic signed [OUT_W-1:0] angle_z;
    logic                    taken;
  } tilt_res_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [SMP_W-1:0] acc_x;
    logic signed [SMP_W-1:0] acc_y;
    logic signed [SMP_W-1:0] acc_z;
    logic [3:0]              typed;
    tilt_res_t               want;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [24] = '{
    '{8'h00, 16'sd0, 16'sd0, 16'sd0, TYPED_ALL, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{8'h00, 16'sd1234, -16'sd1234, 16'sd77, TYPED_ALL, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{8'h01, 16'sd0, 16'sd0, 16'sd0, TYPED_ALL, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{8'h02, SMAX, 16'sd0, 16'sd0, TYPED_XZ, '{P90, 16'sd0, P90, 1'b1}},
    '{8'h03, SMIN, 16'sd0, 16'sd0, TYPED_XZ, '{M90, 16'sd0, P90, 1'b1}},
    '{8'h80, 16'sd5, 16'sd5, 16'sd5, TYPED_XZ, '{M90, 16'sd0, P90, 1'b0}},
    '{8'h01, 16'sd0, SMAX, 16'sd0, TYPED_YZ, '{16'sd0, P90, P90, 1'b1}},
    '{8'h02, 16'sd0, SMIN, 16'sd0, TYPED_YZ, '{16'sd0, M90, P90, 1'b1}},
    '{8'hFC, SMAX, SMAX, SMAX, TYPED_YZ, '{16'sd0, M90, P90, 1'b0}},
    '{8'h01, 16'sd0, 16'sd0, SMAX, TYPED_FLAG, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{8'h01, 16'sd0, 16'sd0, SMIN, TYPED_FLAG, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{8'h01, 16'sd1, 16'sd0, 16'sd0, TYPED_XZ, '{P90, 16'sd0, P90, 1'b1}},
    '{8'h01, -16'sd1, 16'sd0, 16'sd0, TYPED_XZ, '{M90, 16'sd0, P90, 1'b1}},
    '{8'h01, 16'sd0, 16'sd1, 16'sd0, TYPED_YZ, '{16'sd0, P90, P90, 1'b1}},
    '{8'h01, 16'sd0, 16'sd0, -16'sd1, TYPED_FLAG, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{8'hFF, SMIN, SMIN, SMIN, TYPED_FLAG, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{8'h01, SMAX, SMAX, SMAX, TYPED_FLAG, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{8'h02, 16'sd1, 16'sd1, 16'sd1, TYPED_FLAG, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{8'h03, -16'sd1, -16'sd1, -16'sd1, TYPED_FLAG, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{8'h55, SMAX, SMIN, 16'sd1, TYPED_FLAG, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{8'hAA, SMIN, SMAX, -16'sd1, TYPED_FLAG, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{8'h04, 16'sd100, 16'sd100, 16'sd100, TYPED_FLAG, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{8'h01, 16'sd100, -16'sd200, 16'sd300, TYPED_FLAG, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{8'h02, -16'sd12000, 16'sd5000, 16'sd16000, TYPED_FLAG,
      '{16'sd0, 16'sd0, 16'sd0, 1'b1}}
  };

  logic clk;
  logic rst_n;

  atl_in_if  in_if ();
  atl_out_if out_if ();

  accel_tilt_angles_core #(
    .ANGLE_FRAC_BITS(FRAC),
    .CORDIC_ITERS   (ITERS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  logic signed [SMP_W-1:0] latched_x, latched_y, latched_z;
  tilt_res_t pending_angles [$];
  int  mismatches;
  bit  quiet_sender;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 1_500_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // |v| with 4 fraction bits
  function automatic longint scaled_abs(input logic signed [SMP_W-1:0] v);
    longint a;
    a = v;
    if (a < 0) a = -a;
    return a * 16;
  endfunction

  function automatic longint scaled_hypot(input logic signed [SMP_W-1:0] p,
                                          input logic signed [SMP_W-1:0] q);
    longint a, b;
    a = p;
    b = q;
    return floor_sqrt(longint'(unsigned'((a * a + b * b) << 8)));
  endfunction

  // vectoring CORDIC on nonnegative magnitudes, sign applied at the end
  function automatic logic signed [OUT_W-1:0] vector_angle(input longint num,
                                                           input longint den,
                                                           input bit     neg);
    longint cx, cy, nx, ny, acc, r;
    if (den == 0 && num == 0) return '0;
    acc = 0;
    if (den == 0) begin
      acc = DEG90_FIX;
    end else begin
      cx = den <<< 8;
      cy = num <<< 8;
      for (int i = 0; i < ITERS && i < 24; i++) begin
        if (cy >= 0) begin
          nx = cx + (cy >>> i);
          ny = cy - (cx >>> i);
          acc += ATAN_DEG[i];
        end else begin
          nx = cx - (cy >>> i);
          ny = cy + (cx >>> i);
          acc -= ATAN_DEG[i];
        end
        cx = nx;
        cy = ny;
      end
    end
    if (acc < 0) acc = 0;
    if (acc > DEG90_FIX) acc = DEG90_FIX;
    r = (acc + (64'sd1 <<< (ATAN_FRAC - FRAC - 1))) >>> (ATAN_FRAC - FRAC);
    if (neg) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return OUT_W'(r);
  endfunction

  function automatic tilt_res_t predict_tilt(input logic [STAT_W-1:0]       st,
                                             input logic signed [SMP_W-1:0] x,
                                             input logic signed [SMP_W-1:0] y,
                                             input logic signed [SMP_W-1:0] z);
    tilt_res_t r;
    bit take;
    take = (st & NEW_MASK) != '0;
    if (take) begin
      latched_x = x;
      latched_y = y;
      latched_z = z;
    end
    r.angle_x = vector_angle(scaled_abs(latched_x), scaled_hypot(latched_y, latched_z),
                             latched_x < 0);
    r.angle_y = vector_angle(scaled_abs(latched_y), scaled_hypot(latched_x, latched_z),
                             latched_y < 0);
    r.angle_z = vector_angle(scaled_hypot(latched_x, latched_y), scaled_abs(latched_z),
                             latched_z < 0);
    r.taken   = take;
    return r;
  endfunction

  function automatic logic signed [SMP_W-1:0] draw_axis();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? SMAX : SMIN;
      2, 3:    return SMP_W'(int'($urandom_range(0, 256)) - 128);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic send_reading(input logic [STAT_W-1:0]       st,
                              input logic signed [SMP_W-1:0] x,
                              input logic signed [SMP_W-1:0] y,
                              input logic signed [SMP_W-1:0] z,
                              input logic [3:0]              typed,
                              input tilt_res_t               want);
    tilt_res_t exp_r;
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.status   <= st;
    in_if.acc_x_in <= x;
    in_if.acc_y_in <= y;
    in_if.acc_z_in <= z;
    do @(posedge clk); while (!in_if.ready);
    exp_r = predict_tilt(st, x, y, z);
    if (typed[3]) exp_r.angle_x = want.angle_x;
    if (typed[2]) exp_r.angle_y = want.angle_y;
    if (typed[1]) exp_r.angle_z = want.angle_z;
    if (typed[0]) exp_r.taken   = want.taken;
    pending_angles.push_back(exp_r);
  endtask

  task automatic check_field(input string name, input logic signed [OUT_W-1:0] exp_v,
                             input logic signed [OUT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin
    int stall;
    int got;
    bit quiet;
    tilt_res_t exp_r;
    got = 0;
    quiet = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (got % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      stall = (got == HOLD_AFTER) ? HOLD_CYCLES : (quiet ? 0 : $urandom_range(0, 15));
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got++;
      if (pending_angles.size() == 0) begin
        $error("result transaction with nothing pending");
        mismatches++;
      end else begin
        exp_r = pending_angles.pop_front();
        check_field("angle_x", exp_r.angle_x, out_if.angle_x);
        check_field("angle_y", exp_r.angle_y, out_if.angle_y);
        check_field("angle_z", exp_r.angle_z, out_if.angle_z);
        check_field("sample_taken", OUT_W'(exp_r.taken), OUT_W'(out_if.sample_taken));
      end
    end
  end

  initial begin
    logic [STAT_W-1:0] st;
    mismatches   = 0;
    quiet_sender = 1'b0;
    latched_x    = '0;
    latched_y    = '0;
    latched_z    = '0;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.status   <= '0;
    in_if.acc_x_in <= '0;
    in_if.acc_y_in <= '0;
    in_if.acc_z_in <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i])
      send_reading(DIRECTED_ROWS[i].status, DIRECTED_ROWS[i].acc_x, DIRECTED_ROWS[i].acc_y,
                   DIRECTED_ROWS[i].acc_z, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
      st = STAT_W'($urandom);
      // mostly fresh samples; the rest keep the latched one
      if ($urandom_range(0, 3) == 0) st[1:0] = 2'b00;
      else if (st[1:0] == 2'b00) st[$urandom_range(0, 1)] = 1'b1;
      send_reading(st, draw_axis(), draw_axis(), draw_axis(), 4'b0000, '0);
    end
    in_if.valid <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
